// ----- design/safcu_pkg.sv -----
`default_nettype none
package safcu_pkg;

    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 5;
    localparam int KIND_W = 3;
    localparam int FLAG_W = 5;
    localparam int STEPS  = DATA_W;
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC  = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
    localparam logic [OP_W-1:0] OP_SBB  = 5'd3;
    localparam logic [OP_W-1:0] OP_MOV  = 5'd4;
    localparam logic [OP_W-1:0] OP_OR   = 5'd5;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd6;
    localparam logic [OP_W-1:0] OP_SHL  = 5'd7;
    localparam logic [OP_W-1:0] OP_SHR  = 5'd8;
    localparam logic [OP_W-1:0] OP_CMP  = 5'd9;
    localparam logic [OP_W-1:0] OP_TEST = 5'd10;
    localparam logic [OP_W-1:0] OP_NEG  = 5'd11;
    localparam logic [OP_W-1:0] OP_NOT  = 5'd12;
    localparam logic [OP_W-1:0] OP_MUL  = 5'd13;
    localparam logic [OP_W-1:0] OP_DIV  = 5'd14;
    localparam logic [OP_W-1:0] OP_CBW  = 5'd15;
    localparam logic [OP_W-1:0] OP_CWD  = 5'd16;
    localparam logic [OP_W-1:0] OP_COND = 5'd17;

    localparam logic [KIND_W-1:0] CK_ABOVE   = 3'd0;
    localparam logic [KIND_W-1:0] CK_BELOW   = 3'd1;
    localparam logic [KIND_W-1:0] CK_GREATER = 3'd2;
    localparam logic [KIND_W-1:0] CK_LESS    = 3'd3;
    localparam logic [KIND_W-1:0] CK_SIGN    = 3'd4;
    localparam logic [KIND_W-1:0] CK_NEVER   = 3'd5;

    localparam int F_ZERO  = 0;
    localparam int F_SIGN  = 1;
    localparam int F_CARRY = 2;
    localparam int F_BELOW = 3;
    localparam int F_LESS  = 4;

    typedef struct packed {
        logic load;
        logic step;
        logic is_div;
    } t_md_ctrl;

    typedef struct packed {
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [FLAG_W-1:0] flags;
        logic              taken;
        logic              err;
    } t_alu_res;

    function automatic logic [DATA_W-1:0] mask_op(input logic [DATA_W-1:0] v,
                                                  input logic bm);
        mask_op = bm ? {{(DATA_W-BYTE_W){1'b0}}, v[BYTE_W-1:0]} : v;
    endfunction

endpackage
`default_nettype wire

// ----- design/script_alu_flags_condition_unit.sv -----
`default_nettype none
// An input beat is registered and goes to S_FIN; mul and div by a nonzero divisor first
// pass through S_ITER for the 16 one-bit steps of the shared add/subtract unit.
// A new beat is taken only in S_IDLE, so an item must leave S_FIN before the next is taken.
// A finished result waits in the output register while the next beat is taken.
// Synchronous active-low reset clears the flags, the sequencer and the output valid.
module script_alu_flags_condition_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [safcu_pkg::OP_W-1:0]     i_op,
    input  wire                            i_byte_mode,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_left_value,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_right_value,
    input  wire  [safcu_pkg::KIND_W-1:0]   i_cond_kind,
    input  wire                            i_cond_negate,
    input  wire                            i_cond_or_zero,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [safcu_pkg::DATA_W-1:0]   o_result_low,
    output logic [safcu_pkg::DATA_W-1:0]   o_result_high,
    output logic [safcu_pkg::FLAG_W-1:0]   o_flags_out,
    output logic                           o_branch_taken,
    output logic                           o_error
);
    import safcu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ITER = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [FLAG_W-1:0]   r_flags;
    logic                r_out_valid;
    logic [OP_W-1:0]     r_op;
    logic                r_bm;
    logic [DATA_W-1:0]   r_left;
    logic [DATA_W-1:0]   r_right;
    logic [KIND_W-1:0]   r_kind;
    logic                r_neg;
    logic                r_orz;
    logic [DATA_W-1:0]   r_lo;
    logic [DATA_W-1:0]   r_hi;
    logic [FLAG_W-1:0]   r_oflags;
    logic                r_taken;
    logic                r_err;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_finish;
    logic                w_iter_op;
    t_md_ctrl            w_md_ctrl;
    logic [DATA_W-1:0]   w_md_hi;
    logic [DATA_W-1:0]   w_md_lo;
    t_alu_res            w_alu;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_FIN) && w_out_free;
    // divide by zero skips the iterations
    assign w_iter_op  = (i_op == OP_MUL) ||
                        ((i_op == OP_DIV) && (mask_op(i_right_value, i_byte_mode) != '0));

    assign w_md_ctrl.load   = w_in_acc;
    assign w_md_ctrl.step   = (r_state == S_ITER);
    assign w_md_ctrl.is_div = (r_op == OP_DIV);

    safcu_muldiv u_muldiv (
        .i_clk        (i_clk),
        .i_ctrl       (w_md_ctrl),
        .i_load_value (mask_op(i_left_value, i_byte_mode)),
        .i_operand    (mask_op(r_right, r_bm)),
        .o_hi         (w_md_hi),
        .o_lo         (w_md_lo)
    );

    safcu_alu u_alu (
        .i_op        (r_op),
        .i_byte_mode (r_bm),
        .i_left      (r_left),
        .i_right     (r_right),
        .i_kind      (r_kind),
        .i_negate    (r_neg),
        .i_or_zero   (r_orz),
        .i_flags     (r_flags),
        .i_md_hi     (w_md_hi),
        .i_md_lo     (w_md_lo),
        .o_res       (w_alu)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cnt   = '0;
                    n_state = w_iter_op ? S_ITER : S_FIN;
                end
            end
            S_ITER: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(STEPS-1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_finish) begin
                r_flags     <= w_alu.flags;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_op;
            r_bm    <= i_byte_mode;
            r_left  <= i_left_value;
            r_right <= i_right_value;
            r_kind  <= i_cond_kind;
            r_neg   <= i_cond_negate;
            r_orz   <= i_cond_or_zero;
        end
        if (w_finish) begin
            r_lo     <= w_alu.lo;
            r_hi     <= w_alu.hi;
            r_oflags <= w_alu.flags;
            r_taken  <= w_alu.taken;
            r_err    <= w_alu.err;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_low   = r_lo;
    assign o_result_high  = r_hi;
    assign o_flags_out    = r_oflags;
    assign o_branch_taken = r_taken;
    assign o_error        = r_err;

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result beat without a finished item");

    a_iter_only_muldiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> ((r_op == OP_MUL) || (r_op == OP_DIV)))
        else $error("iteration on an op other than mul or div");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (r_op > OP_TEST)) |=> $stable(r_flags))
        else $error("flags changed by an op that must leave them");

    a_fin_writes_flags_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_state == S_IDLE)) |-> (o_flags_out == r_flags))
        else $error("flags output differs from stored flags");
endmodule
`default_nettype wire

// ----- design/safcu_muldiv.sv -----
`default_nettype none
module safcu_muldiv (
    input  wire                            i_clk,
    input  safcu_pkg::t_md_ctrl            i_ctrl,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_load_value,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_operand,
    output logic [safcu_pkg::DATA_W-1:0]   o_hi,
    output logic [safcu_pkg::DATA_W-1:0]   o_lo
);
    import safcu_pkg::*;

    logic [DATA_W-1:0] r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;
    logic [DATA_W:0]   w_a;
    logic [DATA_W:0]   w_b;
    logic [DATA_W+1:0] w_sum;

    // one shared 17-bit add/subtract: shift-add multiply or restoring divide
    always_comb begin
        if (i_ctrl.is_div) begin
            w_a   = {r_hi, r_lo[DATA_W-1]};
            w_b   = {1'b0, i_operand};
            w_sum = {1'b0, w_a} - {1'b0, w_b};
        end else begin
            w_a   = {1'b0, r_hi};
            w_b   = r_lo[0] ? {1'b0, i_operand} : '0;
            w_sum = {1'b0, w_a} + {1'b0, w_b};
        end
    end

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        if (i_ctrl.load) begin
            n_hi = '0;
            n_lo = i_load_value;
        end else if (i_ctrl.step) begin
            if (i_ctrl.is_div) begin
                if (!w_sum[DATA_W+1]) begin
                    n_hi = w_sum[DATA_W-1:0];
                    n_lo = {r_lo[DATA_W-2:0], 1'b1};
                end else begin
                    n_hi = w_a[DATA_W-1:0];
                    n_lo = {r_lo[DATA_W-2:0], 1'b0};
                end
            end else begin
                n_hi = w_sum[DATA_W:1];
                n_lo = {w_sum[0], r_lo[DATA_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;
endmodule
`default_nettype wire

// ----- design/safcu_alu.sv -----
`default_nettype none
module safcu_alu (
    input  wire  [safcu_pkg::OP_W-1:0]     i_op,
    input  wire                            i_byte_mode,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_left,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_right,
    input  wire  [safcu_pkg::KIND_W-1:0]   i_kind,
    input  wire                            i_negate,
    input  wire                            i_or_zero,
    input  wire  [safcu_pkg::FLAG_W-1:0]   i_flags,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_md_hi,
    input  wire  [safcu_pkg::DATA_W-1:0]   i_md_lo,
    output safcu_pkg::t_alu_res            o_res
);
    import safcu_pkg::*;

    logic [DATA_W-1:0]   w_m;
    logic [DATA_W-1:0]   w_l;
    logic [DATA_W-1:0]   w_r;
    logic [DATA_W-1:0]   w_lcmp;
    logic                w_cin;
    logic [DATA_W:0]     w_sum;
    logic [DATA_W:0]     w_diff;
    logic [2*DATA_W-1:0] w_shl;
    logic [DATA_W-1:0]   w_shr;
    logic                w_big_shift;
    logic [DATA_W-1:0]   w_rv;
    logic                w_c;
    logic                w_do_flags;
    logic                w_zero;
    logic signed [DATA_W-1:0] w_ls;
    logic signed [DATA_W-1:0] w_rs;
    logic                w_t;
    logic                w_t2;

    assign w_m    = mask_op('1, i_byte_mode);
    assign w_l    = mask_op(i_left, i_byte_mode);
    assign w_r    = mask_op(i_right, i_byte_mode);
    assign w_cin  = ((i_op == OP_ADC) || (i_op == OP_SBB)) && i_flags[F_CARRY];
    assign w_sum  = {1'b0, w_l} + {1'b0, w_r} + {{DATA_W{1'b0}}, w_cin};
    // bit DATA_W of the difference is the borrow in either width
    assign w_diff = {1'b0, w_l} - {1'b0, w_r} - {{DATA_W{1'b0}}, w_cin};
    assign w_big_shift = (w_r[DATA_W-1:5] != '0);
    assign w_shl  = w_big_shift ? '0 : ({{DATA_W{1'b0}}, w_l} << w_r[4:0]);
    assign w_shr  = w_big_shift ? '0 : (w_l >> w_r[4:0]);

    always_comb begin
        w_rv       = '0;
        w_c        = 1'b0;
        w_do_flags = 1'b1;
        unique case (i_op)
            OP_ADD, OP_ADC: begin
                w_rv = w_sum[DATA_W-1:0];
                w_c  = i_byte_mode ? w_sum[BYTE_W] : w_sum[DATA_W];
            end
            OP_SUB, OP_SBB, OP_CMP: begin
                w_rv = w_diff[DATA_W-1:0];
                w_c  = w_diff[DATA_W];
            end
            OP_MOV:  w_rv = w_r;
            OP_OR:   w_rv = w_l | w_r;
            OP_XOR:  w_rv = w_l ^ w_r;
            OP_TEST: w_rv = w_l & w_r;
            OP_SHL: begin
                w_rv = w_shl[DATA_W-1:0];
                w_c  = i_byte_mode ? (w_shl[2*DATA_W-1:BYTE_W] != '0)
                                   : (w_shl[2*DATA_W-1:DATA_W] != '0);
            end
            OP_SHR:  w_rv = w_shr;
            default: w_do_flags = 1'b0;
        endcase
    end

    // mov compares the source against zero
    assign w_lcmp = (i_op == OP_MOV) ? '0 : w_l;
    assign w_zero = ((w_rv & w_m) == '0);
    assign w_ls   = i_byte_mode ? {{(DATA_W-BYTE_W){w_lcmp[BYTE_W-1]}}, w_lcmp[BYTE_W-1:0]}
                                : w_lcmp;
    assign w_rs   = i_byte_mode ? {{(DATA_W-BYTE_W){w_r[BYTE_W-1]}}, w_r[BYTE_W-1:0]}
                                : w_r;

    always_comb begin
        unique case (i_kind)
            CK_ABOVE:   w_t = !i_flags[F_BELOW];
            CK_BELOW:   w_t = i_flags[F_BELOW];
            CK_GREATER: w_t = !i_flags[F_LESS];
            CK_LESS:    w_t = i_flags[F_LESS];
            CK_SIGN:    w_t = i_flags[F_SIGN];
            CK_NEVER:   w_t = 1'b0;
            default:    w_t = 1'b0;
        endcase
    end

    assign w_t2 = i_or_zero ? (w_t | i_flags[F_ZERO]) : (w_t & !i_flags[F_ZERO]);

    always_comb begin
        o_res       = '0;
        o_res.flags = i_flags;
        if (w_do_flags) begin
            o_res.flags[F_ZERO]  = w_zero;
            o_res.flags[F_SIGN]  = !w_zero && (i_byte_mode ? w_rv[BYTE_W-1] : w_rv[DATA_W-1]);
            o_res.flags[F_CARRY] = w_c;
            o_res.flags[F_BELOW] = (w_lcmp < w_r);
            o_res.flags[F_LESS]  = (w_ls < w_rs);
        end
        unique case (i_op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_MOV, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                o_res.lo = w_rv & w_m;
            OP_NEG: o_res.lo = (~w_l + 1'b1) & w_m;
            OP_NOT: o_res.lo = ~w_l & w_m;
            OP_MUL: begin
                if (i_byte_mode) begin
                    o_res.lo = {{(DATA_W-BYTE_W){1'b0}}, i_md_lo[BYTE_W-1:0]};
                    o_res.hi = {{(DATA_W-BYTE_W){1'b0}}, i_md_lo[DATA_W-1:BYTE_W]};
                end else begin
                    o_res.lo = i_md_lo;
                    o_res.hi = i_md_hi;
                end
            end
            OP_DIV: begin
                if (w_r == '0) begin
                    o_res.err = 1'b1;
                end else begin
                    o_res.lo = i_md_lo & w_m;
                    o_res.hi = i_md_hi;
                end
            end
            OP_CBW: o_res.lo = {{(DATA_W-BYTE_W){i_left[BYTE_W-1]}}, i_left[BYTE_W-1:0]};
            OP_CWD: begin
                o_res.lo = i_left;
                o_res.hi = {DATA_W{i_left[DATA_W-1]}};
            end
            OP_COND: begin
                if (i_kind > CK_NEVER) begin
                    o_res.err = 1'b1;
                end else begin
                    o_res.taken = w_t2 ^ i_negate;
                end
            end
            default: o_res.lo = '0;
        endcase
    end
endmodule
`default_nettype wire
